### src/epoch_seconds_to_calendar_macros.svh
// ----------------------------------------------------------------------------
// epoch seconds to calendar: assertion macros
// Shared property shorthands for the port checker, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// generic clocked property with reset disable
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal keeps its value in the cycle after cond
`define ESC_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> $stable(sig)) \
    else $error(msg);

`endif

### src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: epoch seconds to calendar package
// Widths, calendar constants, divider control types and date helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int unsigned SecsW   = 32;
  localparam int unsigned ProdW   = 2 * SecsW;
  localparam int unsigned DivRemW = 17;
  localparam int unsigned DaysW   = 17;
  localparam int unsigned DoyW    = 9;
  localparam int unsigned YearW   = 8;
  localparam int unsigned MonW    = 4;

  localparam logic [DivRemW-1:0] SecsPerDay  = DivRemW'(86400);
  localparam logic [DivRemW-1:0] SecsPerHour = DivRemW'(3600);
  localparam logic [DivRemW-1:0] SecsPerMin  = DivRemW'(60);
  localparam logic [DivRemW-1:0] DaysPerYear = DivRemW'(365);
  localparam logic [DivRemW-1:0] DaysPerWeek = DivRemW'(7);
  localparam logic [DaysW-1:0]   Days1900To1970 = DaysW'((70 * 365) + 17);

  // reciprocals scaled by 2^32, rounded down, one per divisor
  localparam logic [SecsW-1:0] RecipDay  = SecsW'(64'h1_0000_0000 / 64'd86400);
  localparam logic [SecsW-1:0] RecipHour = SecsW'(64'h1_0000_0000 / 64'd3600);
  localparam logic [SecsW-1:0] RecipMin  = SecsW'(64'h1_0000_0000 / 64'd60);
  localparam logic [SecsW-1:0] RecipYear = SecsW'(64'h1_0000_0000 / 64'd365);
  localparam logic [SecsW-1:0] RecipWeek = SecsW'(64'h1_0000_0000 / 64'd7);

  localparam logic [MonW-1:0] LastMonth = MonW'(11);

  // divider control
  typedef struct packed {
    logic               start;
    logic [SecsW-1:0]   recip;
    logic [DivRemW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

  // leap year, y counted from 1900
  function automatic logic is_leap(input logic [YearW-1:0] y);
    return (y[1:0] == 2'b00) && (y != YearW'(0)) && (y != YearW'(200));
  endfunction

  // days from 1900-01-01 to january 1 of year 1900 + y
  function automatic logic [DaysW-1:0] days_before_year(input logic [YearW-1:0] y);
    logic [DaysW-1:0]  d;
    logic [YearW-1:0]  ym1;
    ym1 = y - YearW'(1);
    d   = DaysW'(y) * DaysPerYear;
    d   = d + DaysW'(ym1 >> 2);
    if (y > YearW'(200)) begin
      d = d - DaysW'(1);
    end
    if (y == YearW'(0)) begin
      d = '0;
    end
    return d;
  endfunction

  // cumulative days before month m (0 = january)
  function automatic logic [DoyW-1:0] cum_days(input logic leap, input logic [MonW-1:0] m);
    logic [DoyW-1:0] c;
    unique case (m)
      4'd0:    c = DoyW'(0);
      4'd1:    c = DoyW'(31);
      4'd2:    c = DoyW'(59);
      4'd3:    c = DoyW'(90);
      4'd4:    c = DoyW'(120);
      4'd5:    c = DoyW'(151);
      4'd6:    c = DoyW'(181);
      4'd7:    c = DoyW'(212);
      4'd8:    c = DoyW'(243);
      4'd9:    c = DoyW'(273);
      4'd10:   c = DoyW'(304);
      4'd11:   c = DoyW'(334);
      default: c = DoyW'(0);
    endcase
    if (leap && (m >= MonW'(2))) begin
      c = c + DoyW'(1);
    end
    return c;
  endfunction

endpackage

### src/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div: shared divide-by-constant unit
// One multiplier estimates the quotient from a scaled reciprocal, multiplies
// the estimate back by the divisor, and one compare and subtract corrects it;
// quotient, remainder and a done pulse follow the estimate, back and fix phases.
// ----------------------------------------------------------------------------
module esc_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  esc_pkg::div_req_t                req_i,
  input  logic [esc_pkg::SecsW-1:0]        dividend_i,
  output esc_pkg::div_rsp_t                rsp_o,
  output logic [esc_pkg::SecsW-1:0]        quot_o,
  output logic [esc_pkg::DivRemW-1:0]      rem_o
);
  import esc_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EST,
    PH_BACK,
    PH_FIX
  } phase_e;

  phase_e             phase_q;
  logic               done_q;
  logic [SecsW-1:0]   dvd_q;
  logic [SecsW-1:0]   recip_q;
  logic [DivRemW-1:0] dsr_q;
  logic [SecsW-1:0]   quot_q;
  logic [SecsW-1:0]   diff_q;
  logic [DivRemW-1:0] rem_q;

  logic [SecsW-1:0]   mul_a;
  logic [SecsW-1:0]   mul_b;
  logic [ProdW-1:0]   prod;
  logic               over;

  // shared multiplier: reciprocal estimate first, then estimate times divisor
  assign mul_a = (phase_q == PH_EST) ? dvd_q : quot_q;
  assign mul_b = (phase_q == PH_EST) ? recip_q : SecsW'(dsr_q);
  assign prod  = ProdW'(mul_a) * ProdW'(mul_b);

  // the estimate is low by at most one
  assign over = diff_q >= SecsW'(dsr_q);

  // operand and result registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q   <= dividend_i;
      recip_q <= req_i.recip;
      dsr_q   <= req_i.divisor;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
        end
        PH_EST: begin
          quot_q <= prod[ProdW-1:SecsW];
        end
        PH_BACK: begin
          diff_q <= dvd_q - prod[SecsW-1:0];
        end
        PH_FIX: begin
          if (over) begin
            quot_q <= quot_q + SecsW'(1);
            rem_q  <= DivRemW'(diff_q - SecsW'(dsr_q));
          end else begin
            rem_q  <= DivRemW'(diff_q);
          end
        end
      endcase
    end
  end

  // phase control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= (phase_q == PH_FIX);
      unique case (phase_q)
        PH_IDLE: begin
          if (req_i.start) begin
            phase_q <= PH_EST;
          end
        end
        PH_EST:  phase_q <= PH_BACK;
        PH_BACK: phase_q <= PH_FIX;
        PH_FIX:  phase_q <= PH_IDLE;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign quot_o     = quot_q;
  assign rem_o      = rem_q;

endmodule

### src/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: unix seconds to broken-down calendar time
// One request at a time: five divisions by constants share one multiplier,
// then a year step-back and a month search; the next request is taken
// only once the result register has accepted the current result, so a
// result stall can hold it.
// Result register lets the next request start while a result waits.
// Asynchronous active-low reset returns the sequencer to idle, no result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [esc_pkg::SecsW-1:0]     epoch_seconds_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [esc_pkg::YearW-1:0]     year_since_1900_o,
  output logic [esc_pkg::MonW-1:0]      month_o,
  output logic [4:0]                    day_of_month_o,
  output logic [2:0]                    weekday_o,
  output logic [4:0]                    hour_o,
  output logic [5:0]                    minute_o,
  output logic [5:0]                    second_o
);
  import esc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DAY,
    ST_DIV_HOUR,
    ST_DIV_MIN,
    ST_DIV_YEAR,
    ST_DIV_WEEK,
    ST_YEAR_FIX,
    ST_MON_SRCH,
    ST_FINISH
  } state_e;

  state_e             state_q;
  div_req_t           div_req_q;
  logic [SecsW-1:0]   div_a_q;
  div_rsp_t           div_rsp;
  logic [SecsW-1:0]   div_quot;
  logic [DivRemW-1:0] div_rem;

  logic [DaysW-1:0]   days_q;
  logic [YearW-1:0]   year_q;
  logic [DoyW-1:0]    doy_q;
  logic [MonW-1:0]    mon_q;
  logic [4:0]         hour_q;
  logic [5:0]         minute_q;
  logic [5:0]         second_q;
  logic [2:0]         weekday_q;
  logic [4:0]         dom_d;

  logic               out_valid_q;
  logic [YearW-1:0]   out_year_q;
  logic [MonW-1:0]    out_mon_q;
  logic [4:0]         out_dom_q;
  logic [2:0]         out_wday_q;
  logic [4:0]         out_hour_q;
  logic [5:0]         out_min_q;
  logic [5:0]         out_sec_q;

  logic [DaysW-1:0]   dby;
  logic [DoyW-1:0]    tab;
  logic               out_free;

  // shared divider
  esc_div u_esc_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req_q),
    .dividend_i (div_a_q),
    .rsp_o      (div_rsp),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // year start and month table for the current candidates
  assign dby      = days_before_year(year_q);
  assign tab      = cum_days(is_leap(year_q), mon_q);
  assign dom_d    = 5'(doy_q - tab + DoyW'(1));
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE);

  // sequencer, working registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // result handshake
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            div_a_q   <= epoch_seconds_i;
            div_req_q <= '{start: 1'b1, recip: RecipDay, divisor: SecsPerDay};
            state_q   <= ST_DIV_DAY;
          end
        end
        ST_DIV_DAY: begin
          if (div_rsp.done) begin
            days_q    <= Days1900To1970 + div_quot[DaysW-1:0];
            div_a_q   <= SecsW'(div_rem);
            div_req_q <= '{start: 1'b1, recip: RecipHour, divisor: SecsPerHour};
            state_q   <= ST_DIV_HOUR;
          end else begin
            div_req_q.start <= 1'b0;
          end
        end
        ST_DIV_HOUR: begin
          if (div_rsp.done) begin
            hour_q    <= div_quot[4:0];
            div_a_q   <= SecsW'(div_rem);
            div_req_q <= '{start: 1'b1, recip: RecipMin, divisor: SecsPerMin};
            state_q   <= ST_DIV_MIN;
          end else begin
            div_req_q.start <= 1'b0;
          end
        end
        ST_DIV_MIN: begin
          if (div_rsp.done) begin
            minute_q  <= div_quot[5:0];
            second_q  <= div_rem[5:0];
            div_a_q   <= SecsW'(days_q);
            div_req_q <= '{start: 1'b1, recip: RecipYear, divisor: DaysPerYear};
            state_q   <= ST_DIV_YEAR;
          end else begin
            div_req_q.start <= 1'b0;
          end
        end
        ST_DIV_YEAR: begin
          if (div_rsp.done) begin
            year_q    <= div_quot[YearW-1:0];
            // 1900-01-01 was a monday
            div_a_q   <= SecsW'(days_q) + SecsW'(1);
            div_req_q <= '{start: 1'b1, recip: RecipWeek, divisor: DaysPerWeek};
            state_q   <= ST_DIV_WEEK;
          end else begin
            div_req_q.start <= 1'b0;
          end
        end
        ST_DIV_WEEK: begin
          if (div_rsp.done) begin
            weekday_q <= div_rem[2:0];
            state_q   <= ST_YEAR_FIX;
          end else begin
            div_req_q.start <= 1'b0;
          end
        end
        ST_YEAR_FIX: begin
          // step the estimate back until the year starts on or before the day
          if ((year_q != '0) && (days_q < dby)) begin
            year_q <= year_q - YearW'(1);
          end else begin
            doy_q   <= DoyW'(days_q - dby);
            mon_q   <= LastMonth;
            state_q <= ST_MON_SRCH;
          end
        end
        ST_MON_SRCH: begin
          if ((mon_q != '0) && (doy_q < tab)) begin
            mon_q <= mon_q - MonW'(1);
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_year_q  <= year_q;
            out_mon_q   <= mon_q + MonW'(1);
            out_dom_q   <= dom_d;
            out_wday_q  <= weekday_q;
            out_hour_q  <= hour_q;
            out_min_q   <= minute_q;
            out_sec_q   <= second_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign year_since_1900_o = out_year_q;
  assign month_o           = out_mon_q;
  assign day_of_month_o    = out_dom_q;
  assign weekday_o         = out_wday_q;
  assign hour_o            = out_hour_q;
  assign minute_o          = out_min_q;
  assign second_o          = out_sec_q;

endmodule

### src/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker: port checker for epoch_seconds_to_calendar
// Watches the request and result ports and checks handshake and ranges.
// ----------------------------------------------------------------------------
`include "epoch_seconds_to_calendar_macros.svh"

module esc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] year_since_1900_o,
  input logic [3:0] month_o,
  input logic [4:0] day_of_month_o,
  input logic [2:0] weekday_o,
  input logic [4:0] hour_o,
  input logic [5:0] minute_o,
  input logic [5:0] second_o
);

  logic in_range;

  // calendar range of the result fields
  assign in_range = (year_since_1900_o >= 8'd70) && (year_since_1900_o <= 8'd206) &&
                    (month_o >= 4'd1) && (month_o <= 4'd12) &&
                    (day_of_month_o >= 5'd1) && (weekday_o <= 3'd6) &&
                    (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59);

  // a stalled result stays offered
  `ESC_ASSERT(a_out_valid_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")

  // a stalled result keeps its year
  `ESC_ASSERT_HOLD(a_out_year_hold, out_valid_o && out_stall_i, year_since_1900_o, "year moved")

  // block is busy right after taking a request
  `ESC_ASSERT(a_busy_after_req, in_valid_i && !in_stall_o |=> in_stall_o, "not busy")

  // every offered result lies in calendar range
  `ESC_ASSERT(a_out_range, out_valid_o |-> in_range, "field out of range")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .year_since_1900_o (year_since_1900_o),
  .month_o           (month_o),
  .day_of_month_o    (day_of_month_o),
  .weekday_o         (weekday_o),
  .hour_o            (hour_o),
  .minute_o          (minute_o),
  .second_o          (second_o)
);

### test/calendar_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_check: request and result watcher for epoch seconds to calendar
// Computes the calendar date of every accepted request by walking whole
// years and months from 1970, queues it, and compares each accepted result
// with the oldest queued date field by field.
// ----------------------------------------------------------------------------
module calendar_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [esc_pkg::SecsW-1:0] epoch_seconds_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [esc_pkg::YearW-1:0] year_since_1900_i,
  input  logic [esc_pkg::MonW-1:0]  month_i,
  input  logic [4:0]                day_of_month_i,
  input  logic [2:0]                weekday_i,
  input  logic [4:0]                hour_i,
  input  logic [5:0]                minute_i,
  input  logic [5:0]                second_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        checked_o,
  output int                        leap_days_o
);

  import esc_pkg::*;

  localparam int MaxPrinted = 30;

  typedef struct packed {
    logic [SecsW-1:0] secs;
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [4:0]       mday;
    logic [2:0]       wday;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [5:0]       second;
  } date_t;

  date_t dates_due[$];

  // y counts years from 1900; 1900 and 2100 are common years
  function automatic int unsigned days_in_year(input int unsigned y);
    return ((y % 4 == 0) && (y != 0) && (y != 200)) ? 366 : 365;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    case (m)
      2:           return days_in_year(y) - 337;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // date of a request: walk years from 1970, then months within the year
  function automatic date_t date_of(input logic [SecsW-1:0] secs);
    int unsigned day_num;
    int unsigned sod;
    int unsigned left;
    int unsigned y;
    int unsigned m;
    date_t d;
    day_num = secs / 32'd86400;
    sod     = secs % 32'd86400;
    left    = day_num;
    y       = 70;
    while (left >= days_in_year(y)) begin
      left = left - days_in_year(y);
      y++;
    end
    m = 1;
    while (left >= days_in_month(y, m)) begin
      left = left - days_in_month(y, m);
      m++;
    end
    d.secs   = secs;
    d.year   = YearW'(y);
    d.month  = MonW'(m);
    d.mday   = 5'(left + 1);
    // 1970-01-01 was a thursday
    d.wday   = 3'((day_num + 4) % 7);
    d.hour   = 5'(sod / 3600);
    d.minute = 6'((sod % 3600) / 60);
    d.second = 6'(sod % 60);
    return d;
  endfunction

  task automatic report(input string msg);
    if (errors_o < MaxPrinted) begin
      $display("calendar_check: %0t: %s", $realtime, msg);
    end
    errors_o++;
  endtask

  task automatic check_field(input string name, input logic [SecsW-1:0] secs,
                             input int unsigned got, input int unsigned want);
    if (got != want) begin
      report($sformatf("%s of %0d is %0d, want %0d", name, secs, got, want));
    end
  endtask

  // result side first, then queue the new request
  always @(posedge clk_i) begin : watch
    date_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (dates_due.size() == 0) begin
          report($sformatf("result %0d/%0d/%0d with no request outstanding",
                           year_since_1900_i, month_i, day_of_month_i));
        end else begin
          want = dates_due.pop_front();
          check_field("year", want.secs, 32'(year_since_1900_i), 32'(want.year));
          check_field("month", want.secs, 32'(month_i), 32'(want.month));
          check_field("day", want.secs, 32'(day_of_month_i), 32'(want.mday));
          check_field("weekday", want.secs, 32'(weekday_i), 32'(want.wday));
          check_field("hour", want.secs, 32'(hour_i), 32'(want.hour));
          check_field("minute", want.secs, 32'(minute_i), 32'(want.minute));
          check_field("second", want.secs, 32'(second_i), 32'(want.second));
          checked_o++;
          if (want.month == MonW'(2) && want.mday == 5'd29) begin
            leap_days_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        dates_due.push_back(date_of(epoch_seconds_i));
      end
      pending_o = dates_due.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: epoch seconds to calendar testbench
// Sends corner dates around midnights, leap days, year ends and the ends of
// the 32-bit range, then random requests spread over the whole span, with
// bursty requests and a random or patterned result stall. The checker judges results.
// ----------------------------------------------------------------------------
module tb;

  import esc_pkg::*;

  localparam int RandomCount = 1600;
  localparam int DrainCycles = 200;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_e;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic [SecsW-1:0] epoch     = '0;
  logic             out_stall = 1'b0;

  logic             in_stall;
  logic             out_valid;
  logic [YearW-1:0] year_since_1900;
  logic [MonW-1:0]  month;
  logic [4:0]       day_of_month;
  logic [2:0]       weekday;
  logic [4:0]       hour;
  logic [5:0]       minute;
  logic [5:0]       second;

  int errors;
  int pending;
  int checked;
  int leap_days;

  int unsigned sent       = 0;
  int unsigned burst_left = 0;
  int unsigned stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;

  logic [SecsW-1:0] corner_q[$];

  epoch_seconds_to_calendar dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .epoch_seconds_i   (epoch),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .year_since_1900_o (year_since_1900),
    .month_o           (month),
    .day_of_month_o    (day_of_month),
    .weekday_o         (weekday),
    .hour_o            (hour),
    .minute_o          (minute),
    .second_o          (second)
  );

  calendar_check u_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .epoch_seconds_i   (epoch),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .year_since_1900_i (year_since_1900),
    .month_i           (month),
    .day_of_month_i    (day_of_month),
    .weekday_i         (weekday),
    .hour_i            (hour),
    .minute_i          (minute),
    .second_i          (second),
    .errors_o          (errors),
    .pending_o         (pending),
    .checked_o         (checked),
    .leap_days_o       (leap_days)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result stall in a mode that is repicked at random
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 512 == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 8);
      default:     out_stall <= ((stall_tick % 7) < 3);
    endcase
  end

  // random request: whole range, whole days, near year starts, range ends
  function automatic logic [SecsW-1:0] random_epoch();
    longint unsigned v;
    int          day_num;
    int unsigned y;
    int unsigned k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: begin
        day_num = $urandom_range(0, 49710);
        case ($urandom_range(0, 3))
          0:       v = longint'(day_num) * 86400;
          1:       v = longint'(day_num) * 86400 + 86399;
          2:       v = longint'(day_num) * 86400 + 43200;
          default: v = longint'(day_num) * 86400 + $urandom_range(0, 86399);
        endcase
      end
      7, 8: begin
        y = $urandom_range(70, 206);
        day_num = 0;
        for (k = 70; k < y; k++) begin
          day_num += ((k % 4 == 0) && (k != 200)) ? 366 : 365;
        end
        // year end, january end, end of february, start of march
        case ($urandom_range(0, 7))
          0:       day_num = day_num - 1;
          1:       day_num = day_num + 30;
          2:       day_num = day_num + 31;
          3:       day_num = day_num + 58;
          4:       day_num = day_num + 59;
          5:       day_num = day_num + 60;
          6:       day_num = day_num + 364;
          default: day_num = day_num + 365;
        endcase
        if (day_num < 0) begin
          day_num = 0;
        end
        v = longint'(day_num) * 86400 + $urandom_range(0, 86399);
      end
      default: begin
        if ($urandom_range(0, 1) == 1) begin
          v = $urandom_range(0, 200000);
        end else begin
          v = 64'hFFFF_FFFF - $urandom_range(0, 200000);
        end
      end
    endcase
    if (v > 64'hFFFF_FFFF) begin
      v = 64'hFFFF_FFFF - $urandom_range(0, 86399);
    end
    return v[SecsW-1:0];
  endfunction

  // one request; bursts end with a short or a long gap
  task automatic offer(input logic [SecsW-1:0] secs);
    in_valid <= 1'b1;
    epoch    <= secs;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        repeat ($urandom_range(10, 160)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // stimulus and verdict
  initial begin
    corner_q = '{
      32'd0,          32'd59,         32'd3599,       32'd86399,
      32'd86400,
      // 1972 leap day and its neighbors
      32'd68169599,   32'd68169600,   32'd68255999,   32'd68256000,
      // start of the last day of 1972
      32'd94607999,   32'd94608000,
      // turn of 2000 and its leap day
      32'd946684799,  32'd946684800,  32'd951782400,
      // signed 32-bit wrap point
      32'd2147483647, 32'd2147483648,
      // 2100 starts and has no leap day
      32'd4102444799, 32'd4102444800, 32'd4107542399, 32'd4107542400,
      // 2104 leap day, last representable second
      32'd4233686400, 32'hFFFF_FFFF,
      32'hAAAA_AAAA,  32'h5555_5555
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = $urandom_range(1, 8);
    foreach (corner_q[i]) begin
      offer(corner_q[i]);
    end
    repeat (RandomCount) begin
      offer(random_epoch());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    $display("tb: %0d requests, %0d dates checked, %0d of them february 29th",
             sent, checked, leap_days);
    $display("tb: %0d field mismatches or stray results", errors);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/esc_pkg.sv
src/esc_div.sv
src/epoch_seconds_to_calendar.sv
src/esc_checker.sv
test/calendar_check.sv
test/tb.sv
